>>> rtl/core/rss_pkg.sv
// ----------------------------------------------------------------------------
// rss_pkg
// shared types, constants and codes of the ray-sphere shade accumulator
// ----------------------------------------------------------------------------
`default_nettype none

package rss_pkg;

    // default geometry
    localparam int SIDE_DEF        = 64;
    localparam int WINDOW_HALF_DEF = 10;

    // configuration register indexes
    localparam logic [2:0] CFG_WINDOW_DIST = 3'd0;
    localparam logic [2:0] CFG_CENTER_X    = 3'd1;
    localparam logic [2:0] CFG_CENTER_Y    = 3'd2;
    localparam logic [2:0] CFG_CENTER_Z    = 3'd3;
    localparam logic [2:0] CFG_LIGHT_X     = 3'd4;
    localparam logic [2:0] CFG_LIGHT_Y     = 3'd5;
    localparam logic [2:0] CFG_LIGHT_Z     = 3'd6;
    localparam logic [2:0] CFG_RADIUS      = 3'd7;

    // register reset values
    localparam logic        [22:0] RST_WINDOW_DIST = 23'd655360;
    localparam logic signed [23:0] RST_CENTER_X    = 24'sd0;
    localparam logic signed [23:0] RST_CENTER_Y    = 24'sd786432;
    localparam logic signed [23:0] RST_CENTER_Z    = 24'sd0;
    localparam logic signed [23:0] RST_LIGHT_X     = 24'sd262144;
    localparam logic signed [23:0] RST_LIGHT_Y     = 24'sd262144;
    localparam logic signed [23:0] RST_LIGHT_Z     = -24'sd65536;
    localparam logic        [22:0] RST_RADIUS      = 23'd393216;

    localparam logic [16:0] B_MAX = 17'd65536;

    // iterative units
    localparam int DIV_BITS   = 4;
    localparam int DIV_STEPS  = 64 / DIV_BITS;
    localparam int SQRT_STEPS = 16;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic        start;
        logic [63:0] radicand;
    } sqrt_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] root;
    } sqrt_rsp_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    typedef enum logic [5:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_WX_MUL, ST_WX_DIV, ST_WX_WAIT,
        ST_WZ_MUL, ST_WZ_DIV, ST_WZ_WAIT,
        ST_WIN,
        ST_COL_MUL, ST_COL_DIV, ST_COL_WAIT,
        ST_ROW_MUL, ST_ROW_DIV, ST_ROW_WAIT,
        ST_T1, ST_T2, ST_T3, ST_T4,
        ST_D1, ST_D2, ST_D3, ST_D4, ST_D5, ST_D6, ST_D7,
        ST_SQ_WAIT,
        ST_P1, ST_P2, ST_P3, ST_P4,
        ST_U1, ST_U2, ST_U3, ST_U4, ST_U5, ST_NU_WAIT,
        ST_V1, ST_V2, ST_V3, ST_V4, ST_V5, ST_NV_WAIT,
        ST_W1, ST_W2, ST_W3, ST_W4, ST_W5,
        ST_Q_WAIT, ST_B_DIV, ST_B_WAIT,
        ST_MEMRD, ST_MEMWR,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

>>> rtl/core/rss_div.sv
// ----------------------------------------------------------------------------
// rss_div
// unsigned 64 by 32 bit restoring divider, four quotient bits per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module rss_div import rss_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic [31:0] rem_reg;
    logic [63:0] quo_reg;
    logic [31:0] dsr_reg;
    logic [$clog2(DIV_STEPS)-1:0] cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [31:0] rem_next;
    logic [63:0] quo_next;

    always_comb
    begin
        logic [32:0] r;
        logic [63:0] q;
        r = {1'b0, rem_reg};
        q = quo_reg;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            r = {r[31:0], q[63]};
            q = {q[62:0], 1'b0};
            if (r >= {1'b0, dsr_reg})
            begin
                r    = r - {1'b0, dsr_reg};
                q[0] = 1'b1;
            end
        end
        rem_next = r[31:0];
        quo_next = q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dsr_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

>>> rtl/core/rss_sqrt.sv
// ----------------------------------------------------------------------------
// rss_sqrt
// floor square root of a 64 bit value, two root bits per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module rss_sqrt import rss_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire sqrt_req_t req,
    output sqrt_rsp_t      rsp
);

    logic [63:0] rad_reg;
    logic [33:0] rem_reg;
    logic [31:0] root_reg;
    logic [$clog2(SQRT_STEPS)-1:0] cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [63:0] rad_next;
    logic [33:0] rem_next;
    logic [31:0] root_next;

    always_comb
    begin
        logic [35:0] r;
        logic [35:0] trial;
        logic [63:0] a;
        logic [31:0] q;
        r = {2'b00, rem_reg};
        a = rad_reg;
        q = root_reg;
        for (int i = 0; i < 2; i++)
        begin
            r     = {r[33:0], a[63:62]};
            a     = {a[61:0], 2'b00};
            trial = {2'b00, q, 2'b01};
            if (r >= trial)
            begin
                r = r - trial;
                q = {q[30:0], 1'b1};
            end
            else
            begin
                q = {q[30:0], 1'b0};
            end
        end
        rem_next  = r[33:0];
        rad_next  = a;
        root_next = q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rad_reg  <= req.radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.root = root_reg;

endmodule

`default_nettype wire

>>> rtl/core/rss_pixmem.sv
// ----------------------------------------------------------------------------
// rss_pixmem
// pixel sum store, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module rss_pixmem import rss_pkg::*;
#(
    parameter int DEPTH  = SIDE_DEF * SIDE_DEF,
    parameter int ADDR_W = $clog2(SIDE_DEF * SIDE_DEF)
)
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [31:0]       wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic [31:0]            rdata
);

    logic [31:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/core/ray_sphere_shade_accumulate.sv
// ----------------------------------------------------------------------------
// ray_sphere_shade_accumulate
// traces one ray against a sphere, lambert shades the near hit and adds the
// brightness, saturating, into a square pixel store; mode 1 reads one pixel
// ----------------------------------------------------------------------------
//
// channel  direction  handshake              payload
// in       sink       in_valid / in_stall    mode, dir_x, dir_y, dir_z, read_index
// out      source     out_valid / out_stall  hit, hit_pixel, brightness, stored_value
// cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one item at a time; a traced ray's time is set mostly by the shared divider (up to
// six uses) and the square root unit (up to three uses); a pixel read passes through
// the READ and DONE states
// after reset the pixel store is cleared, one entry a cycle, all SIDE*SIDE entries,
// with no item accepted; config writes are taken at any time
// a finished result waits in the output register while the next item enters
//
`default_nettype none

module ray_sphere_shade_accumulate import rss_pkg::*;
#(
    parameter int SIDE        = SIDE_DEF,
    parameter int WINDOW_HALF = WINDOW_HALF_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // input items
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               mode,
    input  wire logic signed [17:0] dir_x,
    input  wire logic signed [17:0] dir_y,
    input  wire logic signed [17:0] dir_z,
    input  wire logic        [11:0] read_index,
    // result items
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    hit,
    output logic             [11:0] hit_pixel,
    output logic             [16:0] brightness,
    output logic             [31:0] stored_value,
    // configuration writes
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic         [2:0] cfg_index,
    input  wire logic        [23:0] cfg_data
);

    localparam int DEPTH  = SIDE * SIDE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int COL_W  = $clog2(SIDE);
    // window half width and full width in Q16
    localparam logic [22:0] HALF     = 23'(WINDOW_HALF * 65536);
    localparam logic [23:0] TWO_HALF = 24'(2 * WINDOW_HALF * 65536);

    // configuration registers
    logic        [22:0] wd_reg;
    logic signed [23:0] cx_reg, cy_reg, cz_reg;
    logic signed [23:0] lx_reg, ly_reg, lz_reg;
    logic        [22:0] rad_reg;

    state_t state_reg, state_next;

    // item and working registers
    logic signed [17:0] dx_reg, dy_reg, dz_reg;
    logic               rd_ok_reg;
    logic        [40:0] wx_mag_reg, wz_mag_reg;
    logic               wx_neg_reg, wz_neg_reg;
    logic   [COL_W-1:0] col_reg, row_reg;
    logic signed [63:0] prod_reg, prod_next;
    logic signed [63:0] acc_reg, acc_next;
    logic signed [31:0] t_reg, s_reg;
    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic        [31:0] nu_reg, nv_reg;
    logic        [63:0] q_reg;
    logic        [16:0] b_reg;
    logic               res_hit_reg;
    logic        [31:0] res_stored_reg;
    logic  [ADDR_W-1:0] clr_cnt_reg;

    // output register
    logic               out_valid_reg;
    logic               out_hit_reg;
    logic        [11:0] out_pixel_reg;
    logic        [16:0] out_bright_reg;
    logic        [31:0] out_stored_reg;

    // datapath controls
    logic signed [31:0] mul_a, mul_b;
    acc_op_t            acc_op;
    div_req_t           div_req;
    div_rsp_t           div_rsp;
    sqrt_req_t          sqrt_req;
    sqrt_rsp_t          sqrt_rsp;
    logic               mem_we;
    logic  [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic        [31:0] mem_wdata, mem_rdata;

    logic               accept;
    logic               slot_free;
    logic  [ADDR_W-1:0] pix_idx;
    logic signed [31:0] t_now;
    logic signed [31:0] ux, uy, uz, vx, vy, vz;
    logic        [24:0] wx_off, wz_off;
    logic        [63:0] prod_mag;
    logic               prod_neg;
    logic        [32:0] sum_wide;
    logic               win_ok;
    logic               clr_last;

    assign accept    = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    assign out_valid    = out_valid_reg;
    assign hit          = out_hit_reg;
    assign hit_pixel    = out_pixel_reg;
    assign brightness   = out_bright_reg;
    assign stored_value = out_stored_reg;

    // near-hit geometry
    assign t_now = 32'(acc_reg >>> 16);
    assign ux = px_reg - 32'(cx_reg);
    assign uy = py_reg - 32'(cy_reg);
    assign uz = pz_reg - 32'(cz_reg);
    assign vx = 32'(lx_reg) - px_reg;
    assign vy = 32'(ly_reg) - py_reg;
    assign vz = 32'(lz_reg) - pz_reg;

    // sign and magnitude of the projection product
    assign prod_neg = prod_reg[63];
    assign prod_mag = prod_neg ? 64'(-prod_reg) : 64'(prod_reg);

    // window offset, wx + half
    assign wx_off = wx_neg_reg ? 25'(HALF) - 25'(wx_mag_reg) : 25'(HALF) + 25'(wx_mag_reg);
    assign wz_off = wz_neg_reg ? 25'(HALF) - 25'(wz_mag_reg) : 25'(HALF) + 25'(wz_mag_reg);
    assign win_ok = (wx_mag_reg < 41'(HALF)) && (wz_mag_reg < 41'(HALF));

    assign pix_idx  = ADDR_W'(ADDR_W'(col_reg) * ADDR_W'(SIDE)) + ADDR_W'(row_reg);
    assign sum_wide = {1'b0, mem_rdata} + 33'(b_reg);
    assign clr_last = (clr_cnt_reg == ADDR_W'(DEPTH - 1));

    assign prod_next = mul_a * mul_b;

    // accumulator
    always_comb
    begin
        case (acc_op)
            ACC_LOAD: acc_next = prod_reg;
            ACC_ADD:  acc_next = acc_reg + prod_reg;
            ACC_SUB:  acc_next = acc_reg - prod_reg;
            default:  acc_next = acc_reg;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:    if (clr_last) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (mode)              state_next = ST_READ;
                    else if (dir_y <= 0)   state_next = ST_DONE;
                    else                   state_next = ST_WX_MUL;
                end
            end
            ST_READ:     state_next = ST_DONE;
            ST_WX_MUL:   state_next = ST_WX_DIV;
            ST_WX_DIV:   state_next = ST_WX_WAIT;
            ST_WX_WAIT:  if (div_rsp.done) state_next = ST_WZ_MUL;
            ST_WZ_MUL:   state_next = ST_WZ_DIV;
            ST_WZ_DIV:   state_next = ST_WZ_WAIT;
            ST_WZ_WAIT:  if (div_rsp.done) state_next = ST_WIN;
            ST_WIN:      state_next = win_ok ? ST_COL_MUL : ST_DONE;
            ST_COL_MUL:  state_next = ST_COL_DIV;
            ST_COL_DIV:  state_next = ST_COL_WAIT;
            ST_COL_WAIT: if (div_rsp.done) state_next = ST_ROW_MUL;
            ST_ROW_MUL:  state_next = ST_ROW_DIV;
            ST_ROW_DIV:  state_next = ST_ROW_WAIT;
            ST_ROW_WAIT: if (div_rsp.done) state_next = ST_T1;
            ST_T1:       state_next = ST_T2;
            ST_T2:       state_next = ST_T3;
            ST_T3:       state_next = ST_T4;
            ST_T4:       state_next = ST_D1;
            ST_D1:       state_next = ST_D2;
            ST_D2:       state_next = ST_D3;
            ST_D3:       state_next = ST_D4;
            ST_D4:       state_next = ST_D5;
            ST_D5:       state_next = ST_D6;
            ST_D6:       state_next = ST_D7;
            ST_D7:       state_next = acc_reg[63] ? ST_DONE : ST_SQ_WAIT;
            ST_SQ_WAIT:  if (sqrt_rsp.done) state_next = ST_P1;
            ST_P1:       state_next = ST_P2;
            ST_P2:       state_next = ST_P3;
            ST_P3:       state_next = ST_P4;
            ST_P4:       state_next = ST_U1;
            ST_U1:       state_next = ST_U2;
            ST_U2:       state_next = ST_U3;
            ST_U3:       state_next = ST_U4;
            ST_U4:       state_next = ST_U5;
            ST_U5:       state_next = ST_NU_WAIT;
            ST_NU_WAIT:  if (sqrt_rsp.done) state_next = ST_V1;
            ST_V1:       state_next = ST_V2;
            ST_V2:       state_next = ST_V3;
            ST_V3:       state_next = ST_V4;
            ST_V4:       state_next = ST_V5;
            ST_V5:       state_next = ST_NV_WAIT;
            ST_NV_WAIT:  if (sqrt_rsp.done) state_next = ST_W1;
            ST_W1:       state_next = ST_W2;
            ST_W2:       state_next = ST_W3;
            ST_W3:       state_next = ST_W4;
            ST_W4:       state_next = ST_W5;
            ST_W5:
            begin
                // dark side or degenerate vector: no division needed
                if (acc_reg[63] || acc_reg == 0 || nu_reg == 0 || nv_reg == 0)
                    state_next = ST_MEMRD;
                else
                    state_next = ST_Q_WAIT;
            end
            ST_Q_WAIT:   if (div_rsp.done) state_next = ST_B_DIV;
            ST_B_DIV:    state_next = ST_B_WAIT;
            ST_B_WAIT:   if (div_rsp.done) state_next = ST_MEMRD;
            ST_MEMRD:    state_next = ST_MEMWR;
            ST_MEMWR:    state_next = ST_DONE;
            ST_DONE:     if (slot_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath controls per state
    always_comb
    begin
        mul_a             = '0;
        mul_b             = '0;
        acc_op            = ACC_HOLD;
        div_req.start     = 1'b0;
        div_req.dividend  = prod_mag;
        div_req.divisor   = 32'(dy_reg);
        sqrt_req.start    = 1'b0;
        sqrt_req.radicand = 64'(acc_reg);
        mem_we            = 1'b0;
        mem_waddr         = pix_idx;
        mem_wdata         = sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];
        mem_raddr         = pix_idx;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
            end
            ST_IDLE:     mem_raddr = ADDR_W'(read_index);
            ST_WX_MUL:   begin mul_a = 32'(dx_reg); mul_b = 32'({9'b0, wd_reg}); end
            ST_WZ_MUL:   begin mul_a = 32'(dz_reg); mul_b = 32'({9'b0, wd_reg}); end
            ST_WX_DIV, ST_WZ_DIV: div_req.start = 1'b1;
            ST_COL_MUL:  begin mul_a = 32'(wx_off); mul_b = 32'(SIDE); end
            ST_ROW_MUL:  begin mul_a = 32'(wz_off); mul_b = 32'(SIDE); end
            ST_COL_DIV, ST_ROW_DIV:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = 64'(prod_reg);
                div_req.divisor  = 32'(TWO_HALF);
            end
            // t = dot(dir, center) >> 16
            ST_T1:       begin mul_a = 32'(dx_reg); mul_b = 32'(cx_reg); end
            ST_T2:       begin mul_a = 32'(dy_reg); mul_b = 32'(cy_reg); acc_op = ACC_LOAD; end
            ST_T3:       begin mul_a = 32'(dz_reg); mul_b = 32'(cz_reg); acc_op = ACC_ADD; end
            ST_T4:       acc_op = ACC_ADD;
            // disc = t*t + r*r - |c|^2
            ST_D1:       begin mul_a = t_now; mul_b = t_now; end
            ST_D2:
            begin
                mul_a  = 32'({9'b0, rad_reg});
                mul_b  = 32'({9'b0, rad_reg});
                acc_op = ACC_LOAD;
            end
            ST_D3:       begin mul_a = 32'(cx_reg); mul_b = 32'(cx_reg); acc_op = ACC_ADD; end
            ST_D4:       begin mul_a = 32'(cy_reg); mul_b = 32'(cy_reg); acc_op = ACC_SUB; end
            ST_D5:       begin mul_a = 32'(cz_reg); mul_b = 32'(cz_reg); acc_op = ACC_SUB; end
            ST_D6:       acc_op = ACC_SUB;
            ST_D7:       sqrt_req.start = !acc_reg[63];
            // hit point p = s * dir >> 16
            ST_P1:       begin mul_a = s_reg; mul_b = 32'(dx_reg); end
            ST_P2:       begin mul_a = s_reg; mul_b = 32'(dy_reg); end
            ST_P3:       begin mul_a = s_reg; mul_b = 32'(dz_reg); end
            // |u|^2
            ST_U1:       begin mul_a = ux; mul_b = ux; end
            ST_U2:       begin mul_a = uy; mul_b = uy; acc_op = ACC_LOAD; end
            ST_U3:       begin mul_a = uz; mul_b = uz; acc_op = ACC_ADD; end
            ST_U4:       acc_op = ACC_ADD;
            ST_U5:       sqrt_req.start = 1'b1;
            // |v|^2
            ST_V1:       begin mul_a = vx; mul_b = vx; end
            ST_V2:       begin mul_a = vy; mul_b = vy; acc_op = ACC_LOAD; end
            ST_V3:       begin mul_a = vz; mul_b = vz; acc_op = ACC_ADD; end
            ST_V4:       acc_op = ACC_ADD;
            ST_V5:       sqrt_req.start = 1'b1;
            // u . v
            ST_W1:       begin mul_a = ux; mul_b = vx; end
            ST_W2:       begin mul_a = uy; mul_b = vy; acc_op = ACC_LOAD; end
            ST_W3:       begin mul_a = uz; mul_b = vz; acc_op = ACC_ADD; end
            ST_W4:       acc_op = ACC_ADD;
            ST_W5:
            begin
                div_req.start    = !(acc_reg[63] || acc_reg == 0 || nu_reg == 0
                                     || nv_reg == 0);
                div_req.dividend = 64'(acc_reg);
                div_req.divisor  = nu_reg;
            end
            ST_B_DIV:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {q_reg[47:0], 16'h0000};
                div_req.divisor  = nv_reg;
            end
            ST_MEMWR:    mem_we = 1'b1;
            default:     ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            wd_reg        <= RST_WINDOW_DIST;
            cx_reg        <= RST_CENTER_X;
            cy_reg        <= RST_CENTER_Y;
            cz_reg        <= RST_CENTER_Z;
            lx_reg        <= RST_LIGHT_X;
            ly_reg        <= RST_LIGHT_Y;
            lz_reg        <= RST_LIGHT_Z;
            rad_reg       <= RST_RADIUS;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (state_reg == ST_DONE && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_WINDOW_DIST: wd_reg  <= cfg_data[22:0];
                    CFG_CENTER_X:    cx_reg  <= cfg_data;
                    CFG_CENTER_Y:    cy_reg  <= cfg_data;
                    CFG_CENTER_Z:    cz_reg  <= cfg_data;
                    CFG_LIGHT_X:     lx_reg  <= cfg_data;
                    CFG_LIGHT_Y:     ly_reg  <= cfg_data;
                    CFG_LIGHT_Z:     lz_reg  <= cfg_data;
                    CFG_RADIUS:      rad_reg <= cfg_data[22:0];
                    default:         ;
                endcase
            end
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    dx_reg         <= dir_x;
                    dy_reg         <= dir_y;
                    dz_reg         <= dir_z;
                    rd_ok_reg      <= ({5'b0, read_index} < 17'(DEPTH));
                    res_hit_reg    <= 1'b0;
                    res_stored_reg <= '0;
                    b_reg          <= '0;
                end
            end
            ST_READ:     res_stored_reg <= rd_ok_reg ? mem_rdata : '0;
            ST_WX_DIV:   wx_neg_reg <= prod_neg;
            ST_WZ_DIV:   wz_neg_reg <= prod_neg;
            ST_WX_WAIT:  if (div_rsp.done) wx_mag_reg <= div_rsp.quotient[40:0];
            ST_WZ_WAIT:  if (div_rsp.done) wz_mag_reg <= div_rsp.quotient[40:0];
            ST_COL_WAIT:
            begin
                if (div_rsp.done)
                    col_reg <= (div_rsp.quotient >= 64'(SIDE)) ? COL_W'(SIDE - 1)
                                                               : div_rsp.quotient[COL_W-1:0];
            end
            ST_ROW_WAIT:
            begin
                if (div_rsp.done)
                    row_reg <= (div_rsp.quotient >= 64'(SIDE)) ? COL_W'(SIDE - 1)
                                                               : div_rsp.quotient[COL_W-1:0];
            end
            ST_D1:       t_reg <= t_now;
            ST_SQ_WAIT:  if (sqrt_rsp.done) s_reg <= t_reg - $signed(sqrt_rsp.root);
            ST_P2:       px_reg <= 32'(prod_reg >>> 16);
            ST_P3:       py_reg <= 32'(prod_reg >>> 16);
            ST_P4:       pz_reg <= 32'(prod_reg >>> 16);
            ST_NU_WAIT:  if (sqrt_rsp.done) nu_reg <= sqrt_rsp.root;
            ST_NV_WAIT:  if (sqrt_rsp.done) nv_reg <= sqrt_rsp.root;
            ST_Q_WAIT:   if (div_rsp.done) q_reg <= div_rsp.quotient;
            ST_B_WAIT:
            begin
                if (div_rsp.done)
                    b_reg <= (div_rsp.quotient > 64'(B_MAX)) ? B_MAX
                                                             : div_rsp.quotient[16:0];
            end
            ST_MEMWR:    res_hit_reg <= 1'b1;
            ST_DONE:
            begin
                if (slot_free)
                begin
                    out_hit_reg    <= res_hit_reg;
                    out_pixel_reg  <= res_hit_reg ? 12'(pix_idx) : 12'd0;
                    out_bright_reg <= res_hit_reg ? b_reg : 17'd0;
                    out_stored_reg <= res_stored_reg;
                end
            end
            default:     ;
        endcase
    end

    rss_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    rss_sqrt u_sqrt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sqrt_req),
        .rsp   (sqrt_rsp)
    );

    rss_pixmem
    #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    )
    u_pixmem
    (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire
